FILE: design/vdn_pkg.sv
// Package for the vector dot product and norm block.
// Holds the fixed widths, payload structs and controller/datapath link types.
// No dependencies.
package vdn_pkg;

    // Element and accumulator widths.
    localparam int ELEM_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int PROD_WIDTH = 2 * ELEM_WIDTH;
    localparam int ACC_WIDTH  = 41;
    localparam int SUM_WIDTH  = ACC_WIDTH + 1;
    localparam int OUT_WIDTH  = 42;
    localparam int OUT_FRAC   = 16;

    // Square root geometry: the radicand is the non-negative accumulator
    // shifted up so that the root carries OUT_FRAC fraction bits.
    localparam int NORM_SHIFT = 2 * OUT_FRAC - 2 * FRAC_BITS;
    localparam int RAD_WIDTH  = ACC_WIDTH - 1 + NORM_SHIFT;
    localparam int ROOT_WIDTH = RAD_WIDTH / 2;
    localparam int REM_WIDTH  = ROOT_WIDTH + 3;
    localparam int CNT_WIDTH  = $clog2(ROOT_WIDTH);

    // Mode register values.
    localparam logic MODE_DOT  = 1'b0;
    localparam logic MODE_NORM = 1'b1;

    // Input item.
    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] elem_a;
        logic signed [ELEM_WIDTH-1:0] elem_b;
        logic                         last_elem;
    } in_t;

    // Result item.
    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] result_value;
        logic                        saturated;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
        logic finish_dot;
        logic start_sqrt;
        logic sqrt_step;
        logic sqrt_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic mode;
    } stat_t;

endpackage

FILE: design/vdn_ctrl.sv
// Controller state machine for the vector dot product and norm block.
// Sequences multiply, accumulate and the digit-serial square root.
// Depends on vdn_pkg.
module vdn_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  vdn_pkg::stat_t stat,
    output vdn_pkg::cmd_t cmd,
    output logic          busy
);
    import vdn_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;
    localparam logic [1:0] ST_SQRT = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic [CNT_WIDTH-1:0] cnt_next;
    logic                 cnt_end;

    assign cnt_end = (cnt_reg == CNT_WIDTH'(ROOT_WIDTH - 1));
    assign busy    = (state_reg != ST_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_IDLE;
                if (stat.last)
                begin
                    if (stat.mode == MODE_NORM)
                    begin
                        cmd.start_sqrt = 1'b1;
                        cnt_next       = '0;
                        state_next     = ST_SQRT;
                    end
                    else
                    begin
                        cmd.finish_dot = 1'b1;
                    end
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_end)
                begin
                    cmd.sqrt_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and iteration counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: design/vdn_datapath.sv
// Datapath for the vector dot product and norm block: operand registers,
// multiplier, saturating accumulator, square root unit and result register.
// Depends on vdn_pkg.
module vdn_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  vdn_pkg::cmd_t  cmd,
    output vdn_pkg::stat_t stat,
    input  vdn_pkg::in_t   operand,
    input  logic           mode_we,
    input  logic           mode_wdata,
    output vdn_pkg::out_t  result,
    output logic           done
);
    import vdn_pkg::*;

    logic                         mode_reg;
    logic signed [ELEM_WIDTH-1:0] a_reg;
    logic signed [ELEM_WIDTH-1:0] b_reg;
    logic                         last_reg;
    logic                         op_mode_reg;
    logic signed [PROD_WIDTH-1:0] prod_reg;
    logic signed [ACC_WIDTH-1:0]  acc_reg;
    logic                         clip_reg;
    logic signed [SUM_WIDTH-1:0]  sum;
    logic signed [ACC_WIDTH-1:0]  sum_sat;
    logic                         ovf;
    logic                         clip_next;
    logic [RAD_WIDTH-1:0]         rad_reg;
    logic [REM_WIDTH-1:0]         rem_reg;
    logic [ROOT_WIDTH-1:0]        root_reg;
    logic [REM_WIDTH-1:0]         rem_shift;
    logic [REM_WIDTH-1:0]         trial;
    logic                         fits;
    logic [ROOT_WIDTH-1:0]        root_next;
    logic                         sat_hold_reg;
    out_t                         result_reg;
    logic                         done_reg;

    assign stat.last = last_reg;
    assign stat.mode = op_mode_reg;

    // Mode register, written from the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_DOT;
        else if (mode_we)
            mode_reg <= mode_wdata;
    end

    // Operand capture on an accepted transfer, then the registered product.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg       <= operand.elem_a;
            b_reg       <= operand.elem_b;
            last_reg    <= operand.last_elem;
            op_mode_reg <= mode_reg;
        end
        if (cmd.mul)
        begin
            if (op_mode_reg == MODE_NORM)
                prod_reg <= PROD_WIDTH'(a_reg) * PROD_WIDTH'(a_reg);
            else
                prod_reg <= PROD_WIDTH'(a_reg) * PROD_WIDTH'(b_reg);
        end
    end

    // Wide add with clamping to the accumulator range.
    always_comb
    begin
        sum = SUM_WIDTH'(acc_reg) + SUM_WIDTH'(prod_reg);
        ovf = (sum[SUM_WIDTH-1] != sum[SUM_WIDTH-2]);
        if (!ovf)
            sum_sat = sum[ACC_WIDTH-1:0];
        else if (!sum[SUM_WIDTH-1])
            sum_sat = {1'b0, {(ACC_WIDTH-1){1'b1}}};
        else
            sum_sat = {1'b1, {(ACC_WIDTH-1){1'b0}}};
        clip_next = clip_reg | ovf;
    end

    // Accumulator and clip flag; both clear once a vector ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            clip_reg <= 1'b0;
        end
        else if (cmd.acc)
        begin
            if (last_reg)
            begin
                acc_reg  <= '0;
                clip_reg <= 1'b0;
            end
            else
            begin
                acc_reg  <= sum_sat;
                clip_reg <= clip_next;
            end
        end
    end

    // One root bit per step: bring down two radicand bits and try to subtract.
    always_comb
    begin
        rem_shift = {rem_reg[REM_WIDTH-3:0], rad_reg[RAD_WIDTH-1 -: 2]};
        trial     = {{(REM_WIDTH-ROOT_WIDTH-2){1'b0}}, root_reg, 2'b01};
        fits      = (rem_shift >= trial);
        root_next = {root_reg[ROOT_WIDTH-2:0], fits};
    end

    // Square root registers; a negative sum gives a zero radicand.
    always_ff @(posedge clk)
    begin
        if (cmd.start_sqrt)
        begin
            if (sum_sat[ACC_WIDTH-1])
                rad_reg <= '0;
            else
                rad_reg <= {sum_sat[ACC_WIDTH-2:0], {NORM_SHIFT{1'b0}}};
            rem_reg      <= '0;
            root_reg     <= '0;
            sat_hold_reg <= clip_next;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg  <= {rad_reg[RAD_WIDTH-3:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= root_next;
        end
    end

    // Result register; the payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.finish_dot)
        begin
            result_reg.result_value <= OUT_WIDTH'(sum_sat);
            result_reg.saturated    <= clip_next;
        end
        else if (cmd.sqrt_last)
        begin
            result_reg.result_value <= {{(OUT_WIDTH-ROOT_WIDTH){1'b0}}, root_next};
            result_reg.saturated    <= sat_hold_reg;
        end
    end

    // Result strobe, high for one cycle per finished vector.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish_dot | cmd.sqrt_last;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

FILE: design/vector_dot_product_and_norm.sv
// Top level of the vector dot product and norm block.
// Joins the controller (vdn_ctrl) and the datapath (vdn_datapath); uses vdn_pkg.
//
//   Channel   Handshake              Transfer when         Payload
//   input     start / busy           start && !busy        operand (in_t)
//   result    done (strobe)          done                  result (out_t)
//   config    mode_we                mode_we               mode_wdata
//
// An element passes through the accepting edge, a multiply state and an accumulate
// state, set by the registered multiplier and the 42-bit adder.
// On the last element of a norm vector the 28-bit square root follows, one
// root bit per cycle in the restoring unit.
// The result strobe rises the cycle after the accumulate or the final root step.
// Reset clears the accumulator, clip flag, mode and controller; the receiver
// cannot stall, so each result is shown for exactly one cycle.
module vector_dot_product_and_norm (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  vdn_pkg::in_t  operand,
    input  logic          mode_we,
    input  logic          mode_wdata,
    output vdn_pkg::out_t result,
    output logic          done
);
    import vdn_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencing.
    vdn_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Arithmetic and storage.
    vdn_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .operand    (operand),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .result     (result),
        .done       (done)
    );

endmodule

FILE: design/vdn_checker.sv
// Port-level checker for the vector dot product and norm block, with its bind.
// Depends on vdn_pkg and the top level vector_dot_product_and_norm.
module vdn_port_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input vdn_pkg::in_t  operand,
    input logic          done
);
    import vdn_pkg::*;

    // An accepted transfer always keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted transfer");

    // A result only appears once the block has gone idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Results never come in two adjacent cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // An element that does not end the vector produces no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !operand.last_elem) |=> !done ##1 !done ##1 !done)
        else $error("result after an element that is not last");

endmodule

bind vector_dot_product_and_norm vdn_port_checker u_vdn_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .operand (operand),
    .done    (done)
);

FILE: tb/vdn_checker.sv
`timescale 1ns / 1ps
// Result checker for the vector dot product and norm block.
// Watches element, mode and result transfers, predicts each vector result
// and compares it field by field. Uses vdn_pkg.
module vdn_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  vdn_pkg::in_t  operand,
    input  logic          mode_we,
    input  logic          mode_wdata,
    input  vdn_pkg::out_t result,
    input  logic          done,
    output int            fail_count,
    output int            pending_results,
    output int            results_checked,
    output int            norm_results,
    output int            clipped_results
);
    import vdn_pkg::*;

    localparam longint ACC_MAX = (longint'(1) << (ACC_WIDTH - 1)) - 1;
    localparam longint ACC_MIN = -(longint'(1) << (ACC_WIDTH - 1));

    // Shadow copy of the block state.
    longint acc_sum     = 0;
    bit     clip_seen   = 1'b0;
    logic   mode_now    = MODE_DOT;
    out_t   awaited_results[$];
    int     mismatches  = 0;
    int     checked     = 0;
    int     norms       = 0;
    int     clips       = 0;

    // Floor of the square root, found one root bit at a time from the top.
    function automatic longint unsigned floor_root(input longint unsigned radicand);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int i = ROOT_WIDTH - 1; i >= 0; i--)
        begin
            trial = root | (longint'(1) << i);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root;
    endfunction

    task automatic log_mismatch(input string what, input out_t want, input out_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch (%s) at %0t: expected value %0d sat %0b, got value %0d sat %0b",
                     what, $time, $signed(want.result_value), want.saturated,
                     $signed(got.result_value), got.saturated);
    endtask

    // Add one element into the shadow accumulator; a last element yields a result.
    task automatic accumulate_element(input in_t item);
        longint product;
        longint sum;
        longint value;
        out_t   want;
        if (mode_now == MODE_NORM)
            product = longint'($signed(item.elem_a)) * longint'($signed(item.elem_a));
        else
            product = longint'($signed(item.elem_a)) * longint'($signed(item.elem_b));
        sum = acc_sum + product;
        if (sum > ACC_MAX)
        begin
            sum = ACC_MAX;
            clip_seen = 1'b1;
        end
        else if (sum < ACC_MIN)
        begin
            sum = ACC_MIN;
            clip_seen = 1'b1;
        end
        acc_sum = sum;
        if (item.last_elem)
        begin
            if (mode_now == MODE_NORM)
            begin
                // A negative sum can only come from a mode switch inside the vector.
                value = (acc_sum < 0) ? 0 : longint'(floor_root(acc_sum << NORM_SHIFT));
                norms++;
            end
            else
                value = acc_sum;
            want.result_value = value[OUT_WIDTH-1:0];
            want.saturated    = clip_seen;
            if (clip_seen)
                clips++;
            awaited_results.push_back(want);
            acc_sum   = 0;
            clip_seen = 1'b0;
        end
    endtask

    // Compare a result transfer against the oldest prediction.
    task automatic compare_result(input out_t got);
        out_t want;
        if (awaited_results.size() == 0)
            log_mismatch("no result awaited", '0, got);
        else
        begin
            want = awaited_results.pop_front();
            checked++;
            if (got.result_value !== want.result_value)
                log_mismatch("result_value", want, got);
            if (got.saturated !== want.saturated)
                log_mismatch("saturated", want, got);
        end
    endtask

    // Results are checked before new elements are taken in, since a result
    // can leave in the same cycle that the next element transfers.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_sum   = 0;
            clip_seen = 1'b0;
            mode_now  = MODE_DOT;
            awaited_results.delete();
        end
        else
        begin
            if (done)
                compare_result(result);
            if (start && !busy)
                accumulate_element(operand);
            if (mode_we)
                mode_now = mode_wdata;
        end
        fail_count      <= mismatches;
        pending_results <= awaited_results.size();
        results_checked <= checked;
        norm_results    <= norms;
        clipped_results <= clips;
    end

endmodule

FILE: tb/vector_dot_product_and_norm_tb.sv
`timescale 1ns / 1ps
// Testbench top for the vector dot product and norm block.
// Drives element vectors and mode writes; vdn_checker predicts and compares.
// Depends on vdn_pkg, vector_dot_product_and_norm and vdn_checker.
module vector_dot_product_and_norm_tb;
    import vdn_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 300;
    localparam int CLOSING_ITEMS = 150;
    localparam int LONG_LEN      = 1040;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    in_t  operand;
    logic mode_we;
    logic mode_wdata;
    out_t result;
    logic done;

    int   fail_count;
    int   pending_results;
    int   results_checked;
    int   norm_results;
    int   clipped_results;
    int   cycle_count   = 0;
    int   elements_sent = 0;
    int   gap_pct       = 0;
    logic cur_mode      = MODE_DOT;

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    vector_dot_product_and_norm DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operand    (operand),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .result     (result),
        .done       (done)
    );

    vdn_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operand         (operand),
        .mode_we         (mode_we),
        .mode_wdata      (mode_wdata),
        .result          (result),
        .done            (done),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .norm_results    (norm_results),
        .clipped_results (clipped_results)
    );

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("TB_ERROR");
        $finish;
    end

    // Element value biased toward the range ends, zero and small magnitudes.
    function automatic logic signed [ELEM_WIDTH-1:0] pick_elem();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return ELEM_WIDTH'(int'($urandom_range(0, 1023)) - 512);
            default: return ELEM_WIDTH'($urandom());
        endcase
    endfunction

    function automatic in_t make_elem(input int a, input int b, input bit last);
        in_t item;
        item.elem_a    = ELEM_WIDTH'(a);
        item.elem_b    = ELEM_WIDTH'(b);
        item.last_elem = last;
        return item;
    endfunction

    // Hold off new elements until every predicted result has come out.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // Mode writes only happen once the block has gone quiet.
    task automatic write_mode(input logic value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        mode_we    <= 1'b1;
        mode_wdata <= value;
        @(posedge clk);
        mode_we  <= 1'b0;
        cur_mode = value;
    endtask

    // One element transfer, with an optional idle burst ahead of it.
    task automatic send_elem(input in_t item);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        start   <= 1'b1;
        operand <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        elements_sent++;
    endtask

    // Random vector; now and then the mode flips after its first element.
    task automatic send_vector(input int len, input bit allow_flip);
        in_t item;
        for (int i = 0; i < len; i++)
        begin
            item.elem_a    = pick_elem();
            item.elem_b    = pick_elem();
            item.last_elem = (i == len - 1);
            send_elem(item);
            if (i == 0 && len > 1 && allow_flip && $urandom_range(0, 24) == 0)
                write_mode(!cur_mode);
        end
    endtask

    // Long vector of fixed extreme pairs that drives the accumulator into
    // its clamp, with a few random elements at the tail.
    task automatic send_long_vector(input int a_fix, input int b_fix);
        in_t item;
        for (int i = 0; i < LONG_LEN; i++)
        begin
            if (i < LONG_LEN - 6)
                item = make_elem(a_fix, b_fix, 1'b0);
            else
            begin
                item.elem_a    = pick_elem();
                item.elem_b    = pick_elem();
                item.last_elem = (i == LONG_LEN - 1);
            end
            send_elem(item);
        end
    endtask

    function automatic int pick_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    endfunction

    initial
    begin
        int target;

        rst_n      <= 1'b0;
        start      <= 1'b0;
        operand    <= '0;
        mode_we    <= 1'b0;
        mode_wdata <= MODE_DOT;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed dot products: range ends, zero and a short mixed vector.
        send_elem(make_elem(32767, 32767, 1'b1));
        send_elem(make_elem(-32768, -32768, 1'b1));
        send_elem(make_elem(-32768, 32767, 1'b1));
        send_elem(make_elem(0, 0, 1'b1));
        send_elem(make_elem(256, 256, 1'b0));
        send_elem(make_elem(-256, 512, 1'b0));
        send_elem(make_elem(0, -1, 1'b1));

        // Directed norms; the second operand must have no effect.
        write_mode(MODE_NORM);
        send_elem(make_elem(-32768, 32767, 1'b1));
        send_elem(make_elem(768, -1, 1'b0));
        send_elem(make_elem(1024, 4660, 1'b1));
        send_elem(make_elem(0, -32768, 1'b1));
        send_elem(make_elem(1, 0, 1'b1));
        send_elem(make_elem(32767, 0, 1'b1));

        // Mode switches inside a vector, including a negative sum under norm.
        write_mode(MODE_DOT);
        send_elem(make_elem(-256, 256, 1'b0));
        write_mode(MODE_NORM);
        send_elem(make_elem(0, 100, 1'b1));
        send_elem(make_elem(512, 0, 1'b0));
        write_mode(MODE_DOT);
        send_elem(make_elem(256, -256, 1'b1));

        // Random vectors with idle bursts switched on and off in stretches.
        target = elements_sent + RANDOM_ITEMS;
        while (elements_sent < target)
        begin
            if ($urandom_range(0, 14) == 0)
                write_mode(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 29) == 0)
                drain();
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 40;
                endcase
            end
            send_vector(pick_len(), 1'b1);
        end

        // Saturation at the top end in norm mode, carried through the root.
        gap_pct = 5;
        write_mode(MODE_NORM);
        send_long_vector(32767, -32768);

        // Closing stretch at full rate.
        gap_pct = 0;
        write_mode(1'($urandom_range(0, 1)));
        target = elements_sent + CLOSING_ITEMS;
        while (elements_sent < target)
            send_vector(pick_len(), 1'b0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d vector results (%0d norm, %0d clipped) from %0d element transfers.",
                 results_checked, norm_results, clipped_results, elements_sent);
        $display("Covered range ends, mode switches inside vectors, saturating vectors and gaps.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: vector_dot_product_and_norm.f
design/vdn_pkg.sv
design/vdn_ctrl.sv
design/vdn_datapath.sv
design/vector_dot_product_and_norm.sv
design/vdn_checker.sv
tb/vdn_checker.sv
tb/vector_dot_product_and_norm_tb.sv
